### src/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int STAT_W   = 2;
    localparam int OFF_W    = 26;
    localparam int CNT_W    = 11;
    localparam int BB_W     = 16;
    localparam int STRIDE_W = 17;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    // commands
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_BLOCKS_IN_USE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_BLOCK_BYTES   = 1'b1;

    localparam logic [CNT_W-1:0] RST_BLOCKS_IN_USE = 11'd1024;
    localparam logic [BB_W-1:0]  RST_BLOCK_BYTES   = 16'd64;

    // header plus link in front of each payload
    localparam logic [STRIDE_W+CNT_W-1:0] PAYLOAD_BASE = 28'd32;
    localparam logic [STRIDE_W-1:0]       LINK_BYTES   = 17'd8;

    typedef struct packed {
        logic load;   // take request fields, read link at head
        logic exec;   // update pool state, load result register
    } t_dp_cmd;

    // payload size rounded up to eight plus the link word
    function automatic logic [STRIDE_W-1:0] f_stride(input logic [BB_W-1:0] bb);
        logic [STRIDE_W-1:0] s;
        s = {1'b0, bb} + 17'd7;
        s[2:0] = 3'd0;
        return s + LINK_BYTES;
    endfunction

endpackage

`default_nettype wire

### src/fixed_block_free_list_allocator.sv
// a request is accepted, then executed; the result is registered on execute
// a new request is not taken until the last one has executed; the link memory
//   read at the list head is registered and must land before the pop is applied
// a result waiting at the output holds the execute step until it is taken
// reset: synchronous active low; pool, configuration and control state reset,
//   the link memory, link read, request latch and result registers are not cleared
`default_nettype none

`include "assert_macros.svh"

module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // command [1:0], block_index [11:2], zero [15:12]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // status [1:0], granted_index [11:2], payload_offset [37:12],
    // free_count [48:38], zero [55:49]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_A_W-1:0]     i_cfg_addr,
    input  wire logic [CFG_D_W-1:0]     i_cfg_wdata
);

    t_dp_cmd           dp_cmd;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted_index;
    logic [OFF_W-1:0]  payload_offset;
    logic [CNT_W-1:0]  free_count;

    fbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_dp_cmd   (dp_cmd)
    );

    fbfl_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_command        (i_s_tdata[CMD_W-1:0]),
        .i_block_index    (i_s_tdata[CMD_W+IDX_W-1:CMD_W]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_status         (status),
        .o_granted_index  (granted_index),
        .o_payload_offset (payload_offset),
        .o_free_count     (free_count)
    );

    assign o_m_tdata = {7'd0, free_count, payload_offset, granted_index, status};

    // ready drops for the execute cycle after every accepted request
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // a new result only follows an execute cycle
    `ASSERT_SAME(a_result_after_exec, i_clk, i_rst_n, $rose(o_m_tvalid), $past(!o_s_tready))
    // a failed request never carries a grant
    `ASSERT_SAME(a_fail_no_grant, i_clk, i_rst_n, o_m_tvalid && status != ST_OK,
                 granted_index == '0 && payload_offset == '0)
    // the unused status code is never produced
    `ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_m_tvalid, status != ST_UNUSED)

endmodule

`default_nettype wire

### src/fbfl_ctrl.sv
`default_nettype none

module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    output t_dp_cmd      o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // result slot can take a new value this cycle
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        o_dp_cmd.load = 1'b0;
        o_dp_cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold here while an earlier result is still waiting
                if (out_free) begin
                    o_dp_cmd.exec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

### src/fbfl_dp.sv
`default_nettype none

module fbfl_dp
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_dp_cmd,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [IDX_W-1:0]    i_block_index,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_A_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_D_W-1:0]  i_cfg_wdata,
    output logic [STAT_W-1:0]        o_status,
    output logic [IDX_W-1:0]         o_granted_index,
    output logic [OFF_W-1:0]         o_payload_offset,
    output logic [CNT_W-1:0]         o_free_count
);

    localparam int DEPTH   = (MAX_BLOCKS > (1 << IDX_W)) ? (1 << IDX_W) : MAX_BLOCKS;
    localparam int AW      = $clog2(DEPTH);
    localparam int CAP_INT = (MAX_BLOCKS > ((1 << CNT_W) - 1)) ? ((1 << CNT_W) - 1)
                                                               : MAX_BLOCKS;
    localparam logic [CNT_W-1:0] POOL_CAP = CNT_W'(CAP_INT);
    localparam logic [CNT_W-1:0] RST_POOL =
        (RST_BLOCKS_IN_USE > POOL_CAP) ? POOL_CAP : RST_BLOCKS_IN_USE;
    localparam int PROD_W = STRIDE_W + CNT_W;

    // configuration
    logic [CNT_W-1:0] r_blocks_in_use;
    logic [BB_W-1:0]  r_block_bytes;

    // pool state
    logic                r_head_null, n_head_null;
    logic [AW-1:0]       r_head_idx, n_head_idx;
    logic [CNT_W-1:0]    r_fresh, n_fresh;
    logic [CNT_W-1:0]    r_free_total, n_free_total;
    logic [CNT_W-1:0]    r_pool_count, n_pool_count;
    logic [STRIDE_W-1:0] r_stride, n_stride;

    // latched request and link read
    logic [CMD_W-1:0] r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [AW:0]      r_link [DEPTH];
    logic [AW:0]      r_link_q;
    logic             link_we;

    logic [STAT_W-1:0] n_status;
    logic [IDX_W-1:0]  n_granted;
    logic [OFF_W-1:0]  n_offset;
    logic [CNT_W-1:0]  init_count;
    logic [CNT_W-1:0]  grant;
    logic [PROD_W-1:0] prod;
    logic              got;
    logic [AW-1:0]     idx_a;

    assign init_count = (r_blocks_in_use > POOL_CAP) ? POOL_CAP : r_blocks_in_use;
    assign idx_a      = r_idx[AW-1:0];
    assign grant      = r_head_null ? r_fresh : CNT_W'(r_head_idx);
    assign prod       = PROD_W'(r_stride) * PROD_W'(grant);

    always_comb begin
        n_head_null  = r_head_null;
        n_head_idx   = r_head_idx;
        n_fresh      = r_fresh;
        n_free_total = r_free_total;
        n_pool_count = r_pool_count;
        n_stride     = r_stride;
        n_status     = ST_OK;
        n_granted    = '0;
        n_offset     = '0;
        link_we      = 1'b0;
        got          = 1'b0;
        unique case (r_cmd)
            CMD_INIT: begin
                n_pool_count = init_count;
                n_stride     = f_stride(r_block_bytes);
                n_head_null  = 1'b1;
                n_fresh      = '0;
                n_free_total = init_count;
            end
            CMD_ALLOC: begin
                // returned blocks are served before the fresh counter
                if (!r_head_null) begin
                    n_head_null = r_link_q[AW];
                    n_head_idx  = r_link_q[AW-1:0];
                    got         = 1'b1;
                end else if (r_fresh < r_pool_count) begin
                    n_fresh = r_fresh + 1'b1;
                    got     = 1'b1;
                end
                if (got) begin
                    n_granted = grant[IDX_W-1:0];
                    n_offset  = OFF_W'(prod + PAYLOAD_BASE);
                    if (r_free_total != '0) begin
                        n_free_total = r_free_total - 1'b1;
                    end
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            CMD_FREE: begin
                if ({1'b0, r_idx} >= r_pool_count) begin
                    n_status = ST_RANGE;
                end else begin
                    link_we     = 1'b1;
                    n_head_null = 1'b0;
                    n_head_idx  = idx_a;
                    if (r_free_total != '1) begin
                        n_free_total = r_free_total + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= RST_BLOCKS_IN_USE;
            r_block_bytes   <= RST_BLOCK_BYTES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_wdata[CNT_W-1:0];
                CFG_BLOCK_BYTES:   r_block_bytes   <= i_cfg_wdata[BB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_null  <= 1'b1;
            r_head_idx   <= '0;
            r_fresh      <= '0;
            r_free_total <= RST_POOL;
            r_pool_count <= RST_POOL;
            r_stride     <= f_stride(RST_BLOCK_BYTES);
        end else if (i_dp_cmd.exec) begin
            r_head_null  <= n_head_null;
            r_head_idx   <= n_head_idx;
            r_fresh      <= n_fresh;
            r_free_total <= n_free_total;
            r_pool_count <= n_pool_count;
            r_stride     <= n_stride;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= i_command;
            r_idx <= i_block_index;
        end
        if (i_dp_cmd.exec) begin
            o_status         <= n_status;
            o_granted_index  <= n_granted;
            o_payload_offset <= n_offset;
            o_free_count     <= n_free_total;
        end
    end

    // link memory: read at the head on request, written on a free
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_link_q <= r_link[r_head_idx];
        end
        if (i_dp_cmd.exec && link_we) begin
            r_link[idx_a] <= {r_head_null, r_head_idx};
        end
    end

endmodule

`default_nettype wire
